FILE: rtl/fctu_pkg.sv
// ----------------------------------------------------------------------------
// fctu_pkg: shared types and constants of the FOC coordinate transform unit
// Item layouts, transform codes, quadrant codes and the quarter-wave sine ROM.
// ----------------------------------------------------------------------------
package fctu_pkg;

   // Transform selected by the mode field of an item.
   localparam logic [1:0] MODE_CLARKE   = 2'd0;
   localparam logic [1:0] MODE_PARK     = 2'd1;
   localparam logic [1:0] MODE_INV_PARK = 2'd2;

   // Quadrant codes, as bits [9:8] of the 10-bit table index.
   localparam logic [1:0] QUAD_0_90    = 2'b10;
   localparam logic [1:0] QUAD_90_180  = 2'b11;
   localparam logic [1:0] QUAD_180_270 = 2'b00;
   localparam logic [1:0] QUAD_270_360 = 2'b01;

   // 1/sqrt(3) in Q15.
   localparam logic signed [15:0] INV_SQRT3_Q15 = 16'sh49E6;

   // Symmetric saturation limit.
   localparam int SAT_MAX = 32767;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] in_x;
      logic signed [15:0] in_y;
      logic signed [15:0] angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] sin;
      logic signed [15:0] cos;
   } trig_type;

   // Operands held in the input register: the angle is already resolved.
   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] in_x;
      logic signed [15:0] in_y;
      trig_type           trig;
   } op_type;

   // First quadrant of sin, Q15, peak 0x7FFE.
   localparam logic [15:0] QUARTER_SINE [256] = '{
      16'h0000,16'h00C9,16'h0192,16'h025B,16'h0324,16'h03ED,16'h04B6,16'h057F,
      16'h0648,16'h0711,16'h07D9,16'h08A2,16'h096A,16'h0A33,16'h0AFB,16'h0BC4,
      16'h0C8C,16'h0D54,16'h0E1C,16'h0EE3,16'h0FAB,16'h1072,16'h113A,16'h1201,
      16'h12C8,16'h138F,16'h1455,16'h151C,16'h15E2,16'h16A8,16'h176E,16'h1833,
      16'h18F9,16'h19BE,16'h1A82,16'h1B47,16'h1C0B,16'h1CCF,16'h1D93,16'h1E57,
      16'h1F1A,16'h1FDD,16'h209F,16'h2161,16'h2223,16'h22E5,16'h23A6,16'h2467,
      16'h2528,16'h25E8,16'h26A8,16'h2767,16'h2826,16'h28E5,16'h29A3,16'h2A61,
      16'h2B1F,16'h2BDC,16'h2C99,16'h2D55,16'h2E11,16'h2ECC,16'h2F87,16'h3041,
      16'h30FB,16'h31B5,16'h326E,16'h3326,16'h33DF,16'h3496,16'h354D,16'h3604,
      16'h36BA,16'h376F,16'h3824,16'h38D9,16'h398C,16'h3A40,16'h3AF2,16'h3BA5,
      16'h3C56,16'h3D07,16'h3DB8,16'h3E68,16'h3F17,16'h3FC5,16'h4073,16'h4121,
      16'h41CE,16'h427A,16'h4325,16'h43D0,16'h447A,16'h4524,16'h45CD,16'h4675,
      16'h471C,16'h47C3,16'h4869,16'h490F,16'h49B4,16'h4A58,16'h4AFB,16'h4B9D,
      16'h4C3F,16'h4CE0,16'h4D81,16'h4E20,16'h4EBF,16'h4F5D,16'h4FFB,16'h5097,
      16'h5133,16'h51CE,16'h5268,16'h5302,16'h539B,16'h5432,16'h54C9,16'h5560,
      16'h55F5,16'h568A,16'h571D,16'h57B0,16'h5842,16'h58D3,16'h5964,16'h59F3,
      16'h5A82,16'h5B0F,16'h5B9C,16'h5C28,16'h5CB3,16'h5D3E,16'h5DC7,16'h5E4F,
      16'h5ED7,16'h5F5D,16'h5FE3,16'h6068,16'h60EB,16'h616E,16'h61F0,16'h6271,
      16'h62F1,16'h6370,16'h63EE,16'h646C,16'h64E8,16'h6563,16'h65DD,16'h6656,
      16'h66CF,16'h6746,16'h67BC,16'h6832,16'h68A6,16'h6919,16'h698B,16'h69FD,
      16'h6A6D,16'h6ADC,16'h6B4A,16'h6BB7,16'h6C23,16'h6C8E,16'h6CF8,16'h6D61,
      16'h6DC9,16'h6E30,16'h6E96,16'h6EFB,16'h6F5E,16'h6FC1,16'h7022,16'h7083,
      16'h70E2,16'h7140,16'h719D,16'h71F9,16'h7254,16'h72AE,16'h7307,16'h735E,
      16'h73B5,16'h740A,16'h745F,16'h74B2,16'h7504,16'h7555,16'h75A5,16'h75F3,
      16'h7641,16'h768D,16'h76D8,16'h7722,16'h776B,16'h77B3,16'h77FA,16'h783F,
      16'h7884,16'h78C7,16'h7909,16'h794A,16'h7989,16'h79C8,16'h7A05,16'h7A41,
      16'h7A7C,16'h7AB6,16'h7AEE,16'h7B26,16'h7B5C,16'h7B91,16'h7BC5,16'h7BF8,
      16'h7C29,16'h7C59,16'h7C88,16'h7CB6,16'h7CE3,16'h7D0E,16'h7D39,16'h7D62,
      16'h7D89,16'h7DB0,16'h7DD5,16'h7DFA,16'h7E1D,16'h7E3E,16'h7E5F,16'h7E7E,
      16'h7E9C,16'h7EB9,16'h7ED5,16'h7EEF,16'h7F09,16'h7F21,16'h7F37,16'h7F4D,
      16'h7F61,16'h7F74,16'h7F86,16'h7F97,16'h7FA6,16'h7FB4,16'h7FC1,16'h7FCD,
      16'h7FD8,16'h7FE1,16'h7FE9,16'h7FF0,16'h7FF5,16'h7FF9,16'h7FFD,16'h7FFE
   };

endpackage

FILE: rtl/foc_coordinate_transform_unit_top.sv
// ----------------------------------------------------------------------------
// foc_coordinate_transform_unit_top: Q15 Clarke / Park / inverse Park unit
// An item on req_ carries a mode, two Q15 operands and an electrical angle.
// The sine and cosine of the angle are looked up as the item enters the
// input register; the transform is computed between the input register and
// the result register, which drives rsp_.
// An accepted item is held in the input register until the result register
// advances and takes it. One item is accepted every cycle while req_stall
// is low; the rate is set by the single pass through the multipliers.
// Each item gives exactly one result item. The block holds no state between
// items, so reset only clears the valid flags of both registers.
// When rsp_stall is high the result register holds its item; the input
// register still takes one more item, after which req_stall goes high until
// the result is taken.
// ----------------------------------------------------------------------------
module foc_coordinate_transform_unit_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  fctu_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output fctu_pkg::rsp_type rsp_data
);

   fctu_pkg::trig_type trig;
   fctu_pkg::op_type   op_ff, op_in;
   fctu_pkg::rsp_type  result;
   fctu_pkg::rsp_type  rsp_ff;
   logic               op_valid_ff, op_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               advance;
   logic               accept;

   fctu_trig u_trig (
      .angle (req_data.angle),
      .trig  (trig)
   );

   fctu_xform u_xform (
      .op  (op_ff),
      .rsp (result)
   );

   // The result register moves whenever it is empty or being taken.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = op_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign op_in.mode = req_data.mode;
   assign op_in.in_x = req_data.in_x;
   assign op_in.in_y = req_data.in_y;
   assign op_in.trig = trig;

   assign op_valid_in  = accept || (op_valid_ff && !advance);
   assign rsp_valid_in = advance ? op_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_valid_ff  <= op_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= op_in;
      end
      if (advance && op_valid_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: rtl/fctu_trig.sv
// ----------------------------------------------------------------------------
// fctu_trig: sine and cosine lookup
// Folds the offset angle into one quadrant and reads the quarter-wave table.
// ----------------------------------------------------------------------------
module fctu_trig (
   input  logic signed [15:0] angle,
   output fctu_pkg::trig_type trig
);

   logic [9:0]         idx;
   logic [7:0]         lo;
   logic [7:0]         mir;
   logic signed [15:0] sin_lo;
   logic signed [15:0] sin_mir;

   // Adding half a turn to the angle only flips its top bit.
   assign idx     = {~angle[15], angle[14:6]};
   assign lo      = idx[7:0];
   assign mir     = ~lo;
   assign sin_lo  = $signed(fctu_pkg::QUARTER_SINE[lo]);
   assign sin_mir = $signed(fctu_pkg::QUARTER_SINE[mir]);

   always_comb begin
      case (idx[9:8])
         fctu_pkg::QUAD_0_90: begin
            trig.sin = sin_lo;
            trig.cos = sin_mir;
         end
         fctu_pkg::QUAD_90_180: begin
            trig.sin = sin_mir;
            trig.cos = -sin_lo;
         end
         fctu_pkg::QUAD_180_270: begin
            trig.sin = -sin_lo;
            trig.cos = -sin_mir;
         end
         default: begin
            trig.sin = -sin_mir;
            trig.cos = sin_lo;
         end
      endcase
   end

endmodule

FILE: rtl/fctu_xform.sv
// ----------------------------------------------------------------------------
// fctu_xform: Clarke, Park and inverse Park arithmetic
// Products, sums, the Q15 shift and the output saturation or wrap.
// ----------------------------------------------------------------------------
module fctu_xform (
   input  fctu_pkg::op_type  op,
   output fctu_pkg::rsp_type rsp
);

   typedef logic signed [33:0] wide_type;

   function automatic logic signed [15:0] sat_sym(input wide_type v);
      logic signed [15:0] r;
      if (v > wide_type'(fctu_pkg::SAT_MAX)) begin
         r = 16'(fctu_pkg::SAT_MAX);
      end else if (v < -wide_type'(fctu_pkg::SAT_MAX)) begin
         r = -16'(fctu_pkg::SAT_MAX);
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   logic signed [31:0] xc, xs, yc, ys, kx, ky;
   wide_type           clarke_sum, park_x, park_y, inv_x, inv_y;
   wide_type           clarke_sh, park_x_sh, park_y_sh, inv_x_sh, inv_y_sh;

   assign xc = op.in_x * op.trig.cos;
   assign xs = op.in_x * op.trig.sin;
   assign yc = op.in_y * op.trig.cos;
   assign ys = op.in_y * op.trig.sin;
   assign kx = op.in_x * fctu_pkg::INV_SQRT3_Q15;
   assign ky = op.in_y * fctu_pkg::INV_SQRT3_Q15;

   assign clarke_sum = -wide_type'(kx) - (wide_type'(ky) <<< 1);
   assign park_x     = wide_type'(xc) - wide_type'(ys);
   assign park_y     = wide_type'(xs) + wide_type'(yc);
   assign inv_x      = wide_type'(xc) + wide_type'(ys);
   assign inv_y      = wide_type'(yc) - wide_type'(xs);

   // Arithmetic shifts round toward minus infinity.
   assign clarke_sh = clarke_sum >>> 15;
   assign park_x_sh = park_x >>> 15;
   assign park_y_sh = park_y >>> 15;
   assign inv_x_sh  = inv_x >>> 15;
   assign inv_y_sh  = inv_y >>> 15;

   always_comb begin
      case (op.mode)
         fctu_pkg::MODE_CLARKE: begin
            rsp.out_x = op.in_x;
            rsp.out_y = sat_sym(clarke_sh);
         end
         fctu_pkg::MODE_PARK: begin
            rsp.out_x = sat_sym(park_x_sh);
            rsp.out_y = sat_sym(park_y_sh);
         end
         fctu_pkg::MODE_INV_PARK: begin
            // Inverse Park wraps instead of saturating.
            rsp.out_x = inv_x_sh[15:0];
            rsp.out_y = inv_y_sh[15:0];
         end
         default: begin
            rsp.out_x = '0;
            rsp.out_y = '0;
         end
      endcase
   end

endmodule

FILE: test/foc_coordinate_transform_unit_top_tb.sv
// ----------------------------------------------------------------------------
// foc_coordinate_transform_unit_top_tb: self-checking bench of the FOC unit
// Drives directed Clarke, Park, inverse Park and spare-mode items at the
// operand and angle extremes, then random items. Every result is compared
// with a fixed result or a behavioral model of the Q15 transforms, field
// by field. Both sides idle in random bursts, the receiver holds off once
// to back up the input, the unit drains, and the last run has no idling.
// ----------------------------------------------------------------------------
module foc_coordinate_transform_unit_top_tb;

   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int         HOLD_CYCLES  = 200;
   localparam int         DRAIN_CYCLES = 4;
   localparam int         CYCLE_LIMIT  = 200000;

   typedef struct packed {
      logic              known;
      fctu_pkg::req_type item;
      fctu_pkg::rsp_type result;
   } vector_type;

   // Rows with known set carry a result that follows directly from the
   // transform definition; the others are checked against the model below.
   localparam vector_type DIRECTED_ROWS [0:21] = '{
      {1'b1, fctu_pkg::MODE_CLARKE, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000},
      {1'b1, fctu_pkg::MODE_CLARKE, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF},
      {1'b1, fctu_pkg::MODE_CLARKE, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8001},
      {1'b0, fctu_pkg::MODE_CLARKE, 16'sh7FFF, 16'sh8000, 16'sh1234, 32'h0},
      {1'b0, fctu_pkg::MODE_CLARKE, 16'sh8000, 16'sh7FFF, 16'sh0000, 32'h0},
      {1'b0, fctu_pkg::MODE_CLARKE, 16'sh0001, 16'shFFFF, 16'shFFFF, 32'h0},
      {1'b1, MODE_SPARE, 16'sh7FFF, 16'sh8000, 16'sh4000, 16'sh0000, 16'sh0000},
      {1'b1, MODE_SPARE, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'sh0000, 16'sh0000},
      {1'b1, fctu_pkg::MODE_PARK, 16'sh0000, 16'sh0000, 16'shABCD, 16'sh0000, 16'sh0000},
      {1'b1, fctu_pkg::MODE_INV_PARK, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 16'sh0000},
      {1'b0, fctu_pkg::MODE_PARK, 16'sh7FFF, 16'sh8000, 16'sh8000, 32'h0},
      {1'b0, fctu_pkg::MODE_PARK, 16'sh8000, 16'sh8000, 16'shC000, 32'h0},
      {1'b0, fctu_pkg::MODE_PARK, 16'sh7FFF, 16'sh7FFF, 16'sh2000, 32'h0},
      {1'b0, fctu_pkg::MODE_PARK, 16'sh8000, 16'sh7FFF, 16'sh2000, 32'h0},
      {1'b0, fctu_pkg::MODE_PARK, 16'sh8000, 16'sh8000, 16'shA000, 32'h0},
      {1'b0, fctu_pkg::MODE_PARK, 16'sh1234, 16'shEDCB, 16'sh7FFF, 32'h0},
      {1'b0, fctu_pkg::MODE_INV_PARK, 16'sh7FFF, 16'sh7FFF, 16'sh2000, 32'h0},
      {1'b0, fctu_pkg::MODE_INV_PARK, 16'sh8000, 16'sh8000, 16'sh2000, 32'h0},
      {1'b0, fctu_pkg::MODE_INV_PARK, 16'sh8000, 16'sh7FFF, 16'sh6000, 32'h0},
      {1'b0, fctu_pkg::MODE_INV_PARK, 16'sh4000, 16'shC000, 16'sh003F, 32'h0},
      {1'b0, fctu_pkg::MODE_INV_PARK, 16'sh7FFF, 16'sh0001, 16'sh0040, 32'h0},
      {1'b0, fctu_pkg::MODE_PARK, 16'sh5555, 16'shAAAA, 16'shFFC0, 32'h0}
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fctu_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fctu_pkg::rsp_type rsp_data;

   fctu_pkg::rsp_type pending_results [$];
   fctu_pkg::rsp_type oldest_result;
   int                mismatches    = 0;
   int                cycle_count   = 0;
   bit                sender_idles  = 1'b1;
   bit                rsp_idles     = 1'b1;
   bit                hold_request  = 1'b0;

   foc_coordinate_transform_unit_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   function automatic logic signed [15:0] clamp_q15(input longint value);
      if (value > 32767)
         return 16'sh7FFF;
      if (value < -32767)
         return 16'sh8001;
      return value[15:0];
   endfunction

   // Expected result of one item: sine and cosine from the folded quarter
   // wave, then the selected transform with floor shifts by 15.
   function automatic fctu_pkg::rsp_type transform_item(input fctu_pkg::req_type item);
      logic [15:0]       offset;
      logic [9:0]        index;
      logic [7:0]        lo;
      logic [7:0]        mirror;
      longint            sn;
      longint            cs;
      longint            x;
      longint            y;
      longint            k;
      longint            sum_x;
      longint            sum_y;
      fctu_pkg::rsp_type res;
      offset = item.angle + 16'h8000;
      index  = offset[15:6];
      lo     = index[7:0];
      mirror = 8'hFF - lo;
      case (index[9:8])
         fctu_pkg::QUAD_0_90: begin
            sn = longint'(fctu_pkg::QUARTER_SINE[lo]);
            cs = longint'(fctu_pkg::QUARTER_SINE[mirror]);
         end
         fctu_pkg::QUAD_90_180: begin
            sn = longint'(fctu_pkg::QUARTER_SINE[mirror]);
            cs = -longint'(fctu_pkg::QUARTER_SINE[lo]);
         end
         fctu_pkg::QUAD_180_270: begin
            sn = -longint'(fctu_pkg::QUARTER_SINE[lo]);
            cs = -longint'(fctu_pkg::QUARTER_SINE[mirror]);
         end
         default: begin
            sn = -longint'(fctu_pkg::QUARTER_SINE[mirror]);
            cs = longint'(fctu_pkg::QUARTER_SINE[lo]);
         end
      endcase
      x = item.in_x;
      y = item.in_y;
      k = fctu_pkg::INV_SQRT3_Q15;
      res = '0;
      case (item.mode)
         fctu_pkg::MODE_CLARKE: begin
            res.out_x = item.in_x;
            res.out_y = clamp_q15((-(k * x) - 2 * (k * y)) >>> 15);
         end
         fctu_pkg::MODE_PARK: begin
            res.out_x = clamp_q15((x * cs - y * sn) >>> 15);
            res.out_y = clamp_q15((x * sn + y * cs) >>> 15);
         end
         fctu_pkg::MODE_INV_PARK: begin
            // Inverse Park wraps to 16 bits instead of saturating.
            sum_x = (x * cs + y * sn) >>> 15;
            sum_y = (y * cs - x * sn) >>> 15;
            res.out_x = sum_x[15:0];
            res.out_y = sum_y[15:0];
         end
         default: res = '0;
      endcase
      return res;
   endfunction

   function automatic logic signed [15:0] random_q15();
      logic [31:0] r;
      r = $urandom();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         default: return r[15:0];
      endcase
   endfunction

   function automatic fctu_pkg::req_type random_item();
      logic [31:0]       r;
      int                pick;
      fctu_pkg::req_type item;
      r    = $urandom();
      pick = $urandom_range(0, 15);
      item.mode = (pick < 5) ? fctu_pkg::MODE_CLARKE :
                  (pick < 10) ? fctu_pkg::MODE_PARK :
                  (pick < 15) ? fctu_pkg::MODE_INV_PARK : MODE_SPARE;
      item.in_x = random_q15();
      item.in_y = random_q15();
      // Now and then land within one table step of a quadrant boundary.
      if ($urandom_range(0, 5) == 0)
         item.angle = {r[17:16], 8'h00, r[5:0]};
      else
         item.angle = r[15:0];
      return item;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what, want, got);
      mismatches++;
   endtask

   task automatic offer_item(input fctu_pkg::req_type item,
                             input fctu_pkg::rsp_type expected);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(expected);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected result, out_x", 0, rsp_data.out_x);
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data.out_x !== oldest_result.out_x)
               report_mismatch("out_x", oldest_result.out_x, rsp_data.out_x);
            if (rsp_data.out_y !== oldest_result.out_y)
               report_mismatch("out_y", oldest_result.out_y, rsp_data.out_y);
         end
      end
   end

   // Result side: random stall bursts, or one long hold when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_request = 1'b0;
         end else if (rsp_idles && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      vector_type        row;
      fctu_pkg::req_type item;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 22; i++) begin
         row = DIRECTED_ROWS[i];
         offer_item(row.item, row.known ? row.result : transform_item(row.item));
      end

      repeat (240) begin
         item = random_item();
         offer_item(item, transform_item(item));
      end

      // Back the unit up behind a long receiver hold.
      sender_idles = 1'b0;
      hold_request = 1'b1;
      repeat (40) begin
         item = random_item();
         offer_item(item, transform_item(item));
      end
      sender_idles = 1'b1;

      // Let the unit drain completely before going on.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);

      repeat (200) begin
         item = random_item();
         offer_item(item, transform_item(item));
      end

      sender_idles = 1'b0;
      rsp_idles    = 1'b0;
      repeat (50) begin
         item = random_item();
         offer_item(item, transform_item(item));
      end

      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: filelist.f
rtl/fctu_pkg.sv
rtl/fctu_trig.sv
rtl/fctu_xform.sv
rtl/foc_coordinate_transform_unit_top.sv
test/foc_coordinate_transform_unit_top_tb.sv
